>>> hw/rtl/array_priority_queue_core_macros.svh
// Assertion helpers used by the queue core RTL.
// Each macro expects clk and rst_n to be in scope.
`ifndef ARRAY_PRIORITY_QUEUE_CORE_MACROS_SVH
`define ARRAY_PRIORITY_QUEUE_CORE_MACROS_SVH

// Same-cycle implication.
`define APQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define APQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/apq_pkg.sv
`timescale 1ns / 1ps

package apq_pkg;

    localparam int VALUE_W = 32;
    localparam int PRIO_W  = 8;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Control from the sequencer to the min-search unit.
    typedef struct packed {
        logic en;     // a priority word is on the read port this cycle
        logic first;  // it is slot 0: seed the running minimum
    } cmp_ctrl_t;

endpackage

>>> hw/rtl/apq_store.sv
`timescale 1ns / 1ps

// Entry storage: one write port, one read port, registered read data.
module apq_store #(
    parameter int DEPTH = 8,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [IW-1:0]                       wr_addr,
    input  logic signed [apq_pkg::VALUE_W-1:0]  wr_value,
    input  logic [apq_pkg::PRIO_W-1:0]          wr_prio,
    input  logic [IW-1:0]                       rd_addr,
    output logic signed [apq_pkg::VALUE_W-1:0]  rd_value,
    output logic [apq_pkg::PRIO_W-1:0]          rd_prio
);

    logic signed [apq_pkg::VALUE_W-1:0] value_mem [DEPTH];
    logic [apq_pkg::PRIO_W-1:0]         prio_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            value_mem[wr_addr] <= wr_value;
            prio_mem[wr_addr]  <= wr_prio;
        end
        rd_value <= value_mem[rd_addr];
        rd_prio  <= prio_mem[rd_addr];
    end

endmodule

>>> hw/rtl/apq_cmp.sv
`timescale 1ns / 1ps

// Running minimum over the priorities streamed out of the store.
// Strict less-than keeps the lowest slot on ties (scan is ascending).
module apq_cmp #(
    parameter int IW = 3
) (
    input  logic                        clk,
    input  apq_pkg::cmp_ctrl_t          ctrl,
    input  logic [IW-1:0]               idx,
    input  logic [apq_pkg::PRIO_W-1:0]  prio,
    output logic [IW-1:0]               best_idx_next,
    output logic [IW-1:0]               best_idx
);

    logic [IW-1:0]              best_idx_reg;
    logic [apq_pkg::PRIO_W-1:0] best_prio_reg;
    logic [apq_pkg::PRIO_W-1:0] best_prio_next;
    logic                       take;

    always_comb
    begin
        take           = ctrl.en && (ctrl.first || (prio < best_prio_reg));
        best_idx_next  = take ? idx  : best_idx_reg;
        best_prio_next = take ? prio : best_prio_reg;
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
    end

    assign best_idx = best_idx_reg;

endmodule

>>> hw/rtl/array_priority_queue_core.sv
// Channel | Handshake           | Payload
// --------+---------------------+------------------------------------------
// in      | in_valid / in_stall | cmd, value, priority_req
// out     | out_valid/ out_stall| status, removed_value
//
// One request at a time. Insert, full insert and empty delete go straight
// from acceptance to the response state, which posts the result to the
// output register; the next request is taken once the sequencer is idle.
// Delete on N entries: a scan of the N slots through the single store read
// port (one priority per cycle into the shared compare unit), then the
// winner's value is captured while the last slot is read, then the last
// entry is moved into the hole, then the result is posted.
// Reset clears the count, sequencer and output valid; entry storage is not
// cleared (only slots below the count are ever read).
// in_stall is high whenever the sequencer is busy; a result waiting on
// out_stall holds the sequencer in its response state.
`timescale 1ns / 1ps

`include "array_priority_queue_core_macros.svh"

module array_priority_queue_core #(
    parameter int DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                cmd,
    input  logic signed [apq_pkg::VALUE_W-1:0]  value,
    input  logic [apq_pkg::PRIO_W-1:0]          priority_req,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic signed [apq_pkg::VALUE_W-1:0]  removed_value
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,      // priorities stream through the compare unit
        ST_GET_LAST,  // winner's value arrives; read the last slot
        ST_MOVE,      // last slot arrives; write it over the winner
        ST_RESP       // post result to the output register
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]                      count_reg, count_next;
    logic [IW-1:0]                      rd_idx_reg, rd_idx_next;
    apq_pkg::status_t                   pend_status_reg, pend_status_next;
    logic signed [apq_pkg::VALUE_W-1:0] pend_value_reg, pend_value_next;
    logic                               out_valid_reg, out_valid_next;
    logic [1:0]                         status_reg, status_next;
    logic signed [apq_pkg::VALUE_W-1:0] removed_value_reg, removed_value_next;

    logic                               in_accept;
    logic                               out_free;
    logic [CW-1:0]                      count_m1;
    logic [IW-1:0]                      last_idx;
    logic                               scan_last;
    logic                               full;
    logic                               empty;

    // store ports
    logic                               wr_en;
    logic [IW-1:0]                      wr_addr;
    logic signed [apq_pkg::VALUE_W-1:0] wr_value;
    logic [apq_pkg::PRIO_W-1:0]         wr_prio;
    logic [IW-1:0]                      rd_addr;
    logic signed [apq_pkg::VALUE_W-1:0] rd_value;
    logic [apq_pkg::PRIO_W-1:0]         rd_prio;

    // compare unit
    apq_pkg::cmp_ctrl_t                 cmp_ctrl;
    logic [IW-1:0]                      best_idx_next;
    logic [IW-1:0]                      best_idx;

    apq_store #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_store (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_value (wr_value),
        .wr_prio  (wr_prio),
        .rd_addr  (rd_addr),
        .rd_value (rd_value),
        .rd_prio  (rd_prio)
    );

    apq_cmp #(
        .IW (IW)
    ) u_cmp (
        .clk           (clk),
        .ctrl          (cmp_ctrl),
        .idx           (rd_idx_reg),
        .prio          (rd_prio),
        .best_idx_next (best_idx_next),
        .best_idx      (best_idx)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign count_m1  = count_reg - CW'(1);
    assign last_idx  = count_m1[IW-1:0];
    assign scan_last = (rd_idx_reg == last_idx);
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);

    assign cmp_ctrl.en    = (state_reg == ST_SCAN);
    assign cmp_ctrl.first = (rd_idx_reg == '0);

    // Store read address: next slot while scanning, then winner, then last.
    always_comb
    begin
        unique case (state_reg)
            ST_SCAN:     rd_addr = scan_last ? best_idx_next : rd_idx_reg + IW'(1);
            ST_GET_LAST: rd_addr = last_idx;
            default:     rd_addr = '0;
        endcase
    end

    // Store write: append on insert, fill the hole on delete.
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = count_reg[IW-1:0];
        wr_value = value;
        wr_prio  = priority_req;
        if (state_reg == ST_MOVE)
        begin
            wr_en    = 1'b1;
            wr_addr  = best_idx;
            wr_value = rd_value;
            wr_prio  = rd_prio;
        end
        else if (in_accept && (cmd == apq_pkg::CMD_INSERT) && !full)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        rd_idx_next        = rd_idx_reg;
        pend_status_next   = pend_status_reg;
        pend_value_next    = pend_value_reg;
        out_valid_next     = out_valid_reg && out_stall;
        status_next        = status_reg;
        removed_value_next = removed_value_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    pend_status_next = apq_pkg::STATUS_OK;
                    pend_value_next  = '0;
                    state_next       = ST_RESP;
                    if (cmd == apq_pkg::CMD_INSERT)
                    begin
                        if (full)
                            pend_status_next = apq_pkg::STATUS_FULL;
                        else
                            count_next = count_reg + CW'(1);
                    end
                    else if (empty)
                    begin
                        pend_status_next = apq_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        // slot 0 was addressed this cycle
                        rd_idx_next = '0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                    state_next = ST_GET_LAST;
                else
                    rd_idx_next = rd_idx_reg + IW'(1);
            end
            ST_GET_LAST:
            begin
                pend_value_next = rd_value;
                state_next      = ST_MOVE;
            end
            ST_MOVE:
            begin
                count_next = count_m1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    status_next        = pend_status_reg;
                    removed_value_next = pend_value_reg;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            count_reg         <= '0;
            rd_idx_reg        <= '0;
            pend_status_reg   <= apq_pkg::STATUS_OK;
            pend_value_reg    <= '0;
            out_valid_reg     <= 1'b0;
            status_reg        <= '0;
            removed_value_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            count_reg         <= count_next;
            rd_idx_reg        <= rd_idx_next;
            pend_status_reg   <= pend_status_next;
            pend_value_reg    <= pend_value_next;
            out_valid_reg     <= out_valid_next;
            status_reg        <= status_next;
            removed_value_reg <= removed_value_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign removed_value = removed_value_reg;

    `APQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "entry count above depth")
    `APQ_ASSERT_SAME(a_scan_range, state_reg == ST_SCAN, rd_idx_reg <= last_idx && !empty, "scan index past last entry")
    `APQ_ASSERT_NEXT(a_move_dec, state_reg == ST_MOVE, count_reg == $past(count_m1), "delete did not drop the count")
    `APQ_ASSERT_NEXT(a_empty_code, in_accept && cmd == apq_pkg::CMD_DELETE && empty, pend_status_reg == apq_pkg::STATUS_EMPTY && state_reg == ST_RESP, "empty delete not reported")

endmodule

>>> sim/array_priority_queue_checker.sv
`timescale 1ns / 1ps

module array_priority_queue_checker #(
    parameter int DEPTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic                                cmd,
    input  logic signed [apq_pkg::VALUE_W-1:0]  value,
    input  logic [apq_pkg::PRIO_W-1:0]          priority_req,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [1:0]                          status,
    input  logic signed [apq_pkg::VALUE_W-1:0]  removed_value,
    output int                                  errors,
    output int                                  outstanding
);
    localparam int VALUE_W = apq_pkg::VALUE_W;
    localparam int PRIO_W  = apq_pkg::PRIO_W;

    typedef struct packed {
        apq_pkg::status_t     code;
        logic [VALUE_W-1:0]   removed;
    } outcome_t;

    // shadow copy of the queue contents
    logic [VALUE_W-1:0] held_vals  [DEPTH];
    logic [PRIO_W-1:0]  held_prios [DEPTH];
    int                 held;

    outcome_t awaited [$];

    initial errors = 0;

    function automatic outcome_t apply_request(logic op, logic [VALUE_W-1:0] val,
                                               logic [PRIO_W-1:0] pri);
        outcome_t res;
        int       best;
        res.code    = apq_pkg::STATUS_OK;
        res.removed = '0;
        if (op == apq_pkg::CMD_INSERT)
        begin
            if (held >= DEPTH)
                res.code = apq_pkg::STATUS_FULL;
            else
            begin
                held_vals[held]  = val;
                held_prios[held] = pri;
                held = held + 1;
            end
        end
        else if (held == 0)
        begin
            res.code = apq_pkg::STATUS_EMPTY;
        end
        else
        begin
            // strict less-than keeps the lowest slot on ties
            best = 0;
            for (int i = 1; i < held; i++)
                if (held_prios[i] < held_prios[best])
                    best = i;
            res.removed      = held_vals[best];
            held_vals[best]  = held_vals[held-1];
            held_prios[best] = held_prios[held-1];
            held = held - 1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        if (!rst_n)
        begin
            held = 0;
            awaited.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                awaited.push_back(apply_request(cmd, value, priority_req));
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                begin
                    errors++;
                    $error("unexpected result: status %0d removed_value %0d",
                           status, removed_value);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (status !== want.code)
                    begin
                        errors++;
                        $error("status: expected %0d, actual %0d", want.code, status);
                    end
                    if (removed_value !== want.removed)
                    begin
                        errors++;
                        $error("removed_value: expected %0d, actual %0d",
                               $signed(want.removed), removed_value);
                    end
                end
            end
        end
        outstanding = awaited.size();
    end

endmodule

>>> sim/array_priority_queue_core_tb.sv
`timescale 1ns / 1ps

// Top of the queue testbench. Makes requests on the input channel, stalls
// the result channel at random and gives the verdict; all prediction and
// comparison lives in the checker instance.
module array_priority_queue_core_tb;

    localparam int DEPTH        = 8;
    localparam int VALUE_W      = apq_pkg::VALUE_W;
    localparam int PRIO_W       = apq_pkg::PRIO_W;
    localparam int RANDOM_ITEMS = 2000;
    localparam int SETTLE       = 4 * DEPTH + 20;   // worst delete latency, padded

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       cmd;
    logic signed [VALUE_W-1:0]  value;
    logic [PRIO_W-1:0]          priority_req;
    logic                       out_valid;
    logic                       out_stall;
    logic [1:0]                 status;
    logic signed [VALUE_W-1:0]  removed_value;

    int errors;
    int outstanding;
    bit calm;   // set for stretches with no gaps and no stalls

    array_priority_queue_core #(.DEPTH(DEPTH)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .value         (value),
        .priority_req  (priority_req),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .removed_value (removed_value)
    );

    array_priority_queue_checker #(.DEPTH(DEPTH)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .value         (value),
        .priority_req  (priority_req),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .removed_value (removed_value),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    // 10 ns clock, low first so the first rising edge lands at 5 ns
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: well beyond the slowest legal run (long gaps, long stalls,
    // every request a full-depth delete).
    initial
    begin
        #10_000_000;
        $display("array_priority_queue_core verification failed");
        $finish;
    end

    // Idle length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: runs of ready cycles broken by stall bursts.
    initial
    begin : stall_drive
        int run;
        out_stall = 1'b0;
        forever
        begin
            run = $urandom_range(1, 16);
            repeat (run)
            begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
            run = pick_gap();
            repeat (run)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
        end
    end

    // Present one request at a falling edge and hold it until a rising edge
    // takes it. Returns right after that edge with valid still high, so a
    // back-to-back request just replaces the payload at the next falling edge.
    task automatic send_request(logic op, logic [VALUE_W-1:0] val, logic [PRIO_W-1:0] pri);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        cmd          <= op;
        value        <= val;
        priority_req <= pri;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid and hold off until every pending request has answered.
    // Outstanding is read at falling edges, clear of the checker's update.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        // priorities for the fill-to-full run: three-way tie on 3, extremes
        logic [63:0]        tie_prios;
        logic [VALUE_W-1:0] val;
        logic [PRIO_W-1:0]  pri;
        phase_t             phase;
        bit                 narrow;
        int                 len;
        int                 del_pct;
        int                 sent;

        tie_prios    = 64'h05_03_03_FF_80_03_01_7F;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        cmd          = apq_pkg::CMD_INSERT;
        value        = '0;
        priority_req = '0;
        calm         = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --- directed ---
        // delete on an empty queue
        send_request(apq_pkg::CMD_DELETE, '0, '0);
        // extreme values and priorities; the first delete takes the last slot,
        // so nothing gets moved into the hole
        send_request(apq_pkg::CMD_INSERT, 32'h7FFF_FFFF, 8'hFF);
        send_request(apq_pkg::CMD_INSERT, 32'h8000_0000, 8'h00);
        send_request(apq_pkg::CMD_DELETE, 32'hFFFF_FFFF, 8'hFF);
        send_request(apq_pkg::CMD_DELETE, '0, '0);
        // fill to capacity with tied priorities, then one insert too many
        for (int i = 0; i < DEPTH; i++)
            send_request(apq_pkg::CMD_INSERT,
                         (i == 0) ? 32'hFFFF_FFFF : i * 32'h1111_1111,
                         tie_prios[8*i +: 8]);
        send_request(apq_pkg::CMD_INSERT, 32'h1234_5678, 8'h00);
        // drain completely: ties resolve to the lowest slot, holes get refilled
        for (int i = 0; i < DEPTH; i++)
            send_request(apq_pkg::CMD_DELETE, $urandom, PRIO_W'($urandom));
        send_request(apq_pkg::CMD_DELETE, $urandom, PRIO_W'($urandom));
        // sender holds off until the queue has answered everything
        wait_drained();

        // --- random ---
        // Phases lean toward filling or draining so the queue keeps crossing
        // full and empty; narrow-priority phases force lots of ties.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase  = phase_t'($urandom_range(0, 2));
            calm   = ($urandom_range(0, 4) == 0);
            narrow = ($urandom_range(0, 1) == 1);
            len    = $urandom_range(20, 120);
            case (phase)
                PH_FILL:  del_pct = 25;
                PH_DRAIN: del_pct = 75;
                default:  del_pct = 50;
            endcase
            for (int k = 0; k < len; k++)
            begin
                val = $urandom;
                case ($urandom_range(0, 15))
                    0:       val = 32'h7FFF_FFFF;
                    1:       val = 32'h8000_0000;
                    2:       val = '0;
                    3:       val = 32'hFFFF_FFFF;
                    default: ;
                endcase
                pri = narrow ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
                send_request(($urandom_range(0, 99) < del_pct) ?
                             apq_pkg::CMD_DELETE : apq_pkg::CMD_INSERT,
                             val, pri);
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
                wait_drained();
        end
        calm = 1'b0;

        // --- wind down ---
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("array_priority_queue_core verification clean");
        else
            $display("array_priority_queue_core verification failed");
        $finish;
    end

endmodule
